// ===== hdl/rmq_pkg.sv =====
// shared types and constants for the rotation matrix to quaternion pipeline
// no dependencies; used by every cell of the chain and by the top level
package rmq_pkg;

  localparam int unsigned Lanes     = 3;
  localparam int unsigned ElemW     = 16;
  localparam int unsigned SqrtSteps = 15;
  localparam int unsigned DivSteps  = 17;
  localparam int unsigned RadW      = 30;
  localparam int unsigned SqRemW    = 18;
  localparam int unsigned RootW     = 15;
  localparam int unsigned MagW      = 17;
  localparam int unsigned DivRemW   = 17;
  localparam int unsigned DivW      = 16;
  localparam int unsigned QuoW      = 17;

  // code of the branch equals the output slot of the square-root term
  typedef enum logic [1:0] {
    BrX = 2'd0,
    BrY = 2'd1,
    BrZ = 2'd2,
    BrW = 2'd3
  } branch_e;

  typedef struct packed {
    logic [RadW-1:0]              rad;
    logic [SqRemW-1:0]            rem;
    logic [RootW-1:0]             root;
    branch_e                      br;
    logic [Lanes-1:0]             neg;
    logic [Lanes-1:0][MagW-1:0]   mag;
  } sqrt_t;

  typedef struct packed {
    logic [RootW-1:0]             q;
    branch_e                      br;
    logic [Lanes-1:0]             neg;
    logic [Lanes-1:0]             zero;
    logic [Lanes-1:0]             ovf;
    logic [Lanes-1:0][RadW-1:0]   dvd;
    logic [Lanes-1:0][DivRemW-1:0] rem;
    logic [Lanes-1:0][QuoW-1:0]   quo;
  } div_t;

endpackage

// ===== hdl/rmq_if.sv =====
// valid/ready channels for matrix items and quaternion items
// depends on rmq_pkg for the element width
interface rmq_in_if;
  logic                              valid;
  logic                              ready;
  logic signed [rmq_pkg::ElemW-1:0]  elem_0;
  logic signed [rmq_pkg::ElemW-1:0]  elem_1;
  logic signed [rmq_pkg::ElemW-1:0]  elem_2;
  logic signed [rmq_pkg::ElemW-1:0]  elem_3;
  logic signed [rmq_pkg::ElemW-1:0]  elem_4;
  logic signed [rmq_pkg::ElemW-1:0]  elem_5;
  logic signed [rmq_pkg::ElemW-1:0]  elem_6;
  logic signed [rmq_pkg::ElemW-1:0]  elem_7;
  logic signed [rmq_pkg::ElemW-1:0]  elem_8;
  modport source (output valid, elem_0, elem_1, elem_2, elem_3, elem_4, elem_5, elem_6,
                  elem_7, elem_8, input ready);
  modport sink (input valid, elem_0, elem_1, elem_2, elem_3, elem_4, elem_5, elem_6,
                elem_7, elem_8, output ready);
endinterface

interface rmq_out_if;
  logic                              valid;
  logic                              ready;
  logic signed [rmq_pkg::ElemW-1:0]  quat_x;
  logic signed [rmq_pkg::ElemW-1:0]  quat_y;
  logic signed [rmq_pkg::ElemW-1:0]  quat_z;
  logic signed [rmq_pkg::ElemW-1:0]  quat_w;
  modport source (output valid, quat_x, quat_y, quat_z, quat_w, input ready);
  modport sink (input valid, quat_x, quat_y, quat_z, quat_w, output ready);
endinterface

// ===== hdl/rotation_matrix_to_quaternion.sv =====
// rotation matrix to quaternion, Shepperd's method in Q2.14 fixed point
// depends on rmq_pkg, rmq_if and the cells rmq_front, rmq_sqrt_cell, rmq_prep,
// rmq_div_cell, rmq_back
//
// in_i carries one matrix item: nine Q2.14 elements, diagonal on 0, 4, 8.
// out_o carries one quaternion item (x, y, z, w) in Q2.14 for each matrix.
// both channels move an item when valid and ready are high at a clock edge.
// the block is a chain of 35 cells: input cell, 15 square-root cells (one
// root bit each), a rounding and setup cell, 17 divide cells (one quotient
// bit each for the three divided components) and the output cell.
// one item per cycle can be taken while the receiver keeps out_o.ready high;
// the rate is set by the handoff of items from cell to cell in the chain.
// each cell holds its own item and takes a new one when it is empty or its
// neighbor takes the item it holds, so when the receiver stalls the chain
// packs up behind the output register and in_i.ready falls only once every
// cell holds an item. reset empties every cell; no item is in flight after.
module rotation_matrix_to_quaternion (
  input  logic    clk_i,
  input  logic    rst_ni,
  rmq_in_if.sink  in_i,
  rmq_out_if.source out_o
);

  logic                 sq_valid [rmq_pkg::SqrtSteps+1];
  logic                 sq_ready [rmq_pkg::SqrtSteps+1];
  rmq_pkg::sqrt_t       sq_data  [rmq_pkg::SqrtSteps+1];
  logic                 dv_valid [rmq_pkg::DivSteps+1];
  logic                 dv_ready [rmq_pkg::DivSteps+1];
  rmq_pkg::div_t        dv_data  [rmq_pkg::DivSteps+1];

  rmq_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (in_i),
    .out_valid_o (sq_valid[0]),
    .out_ready_i (sq_ready[0]),
    .out_data_o  (sq_data[0])
  );

  for (genvar i = 0; i < rmq_pkg::SqrtSteps; i++) begin : g_sqrt
    rmq_sqrt_cell u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .in_valid_i  (sq_valid[i]),
      .in_ready_o  (sq_ready[i]),
      .in_data_i   (sq_data[i]),
      .out_valid_o (sq_valid[i+1]),
      .out_ready_i (sq_ready[i+1]),
      .out_data_o  (sq_data[i+1])
    );
  end

  rmq_prep u_prep (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (sq_valid[rmq_pkg::SqrtSteps]),
    .in_ready_o  (sq_ready[rmq_pkg::SqrtSteps]),
    .in_data_i   (sq_data[rmq_pkg::SqrtSteps]),
    .out_valid_o (dv_valid[0]),
    .out_ready_i (dv_ready[0]),
    .out_data_o  (dv_data[0])
  );

  for (genvar i = 0; i < rmq_pkg::DivSteps; i++) begin : g_div
    rmq_div_cell u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .in_valid_i  (dv_valid[i]),
      .in_ready_o  (dv_ready[i]),
      .in_data_i   (dv_data[i]),
      .out_valid_o (dv_valid[i+1]),
      .out_ready_i (dv_ready[i+1]),
      .out_data_o  (dv_data[i+1])
    );
  end

  rmq_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (dv_valid[rmq_pkg::DivSteps]),
    .in_ready_o (dv_ready[rmq_pkg::DivSteps]),
    .in_data_i  (dv_data[rmq_pkg::DivSteps]),
    .out_o      (out_o)
  );

endmodule

// ===== hdl/rmq_front.sv =====
// input cell: branch choice, radicand and the three signed numerators
// depends on rmq_pkg and rmq_if
module rmq_front (
  input  logic               clk_i,
  input  logic               rst_ni,
  rmq_in_if.sink             in_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output rmq_pkg::sqrt_t     out_data_o
);

  logic                  valid_q;
  rmq_pkg::sqrt_t        data_q, data_d;
  logic signed [18:0]    a0, a1, a2, a3, a4, a5, a6, a7, a8;
  logic signed [18:0]    tr, s;
  logic signed [18:0]    na, nb, nc, nd, ne, nf;
  logic signed [18:0]    n [rmq_pkg::Lanes];
  rmq_pkg::branch_e      br;

  assign in_i.ready  = !valid_q || out_ready_i;
  assign out_valid_o = valid_q;
  assign out_data_o  = data_q;

  always_comb begin
    a0 = 19'(in_i.elem_0);
    a1 = 19'(in_i.elem_1);
    a2 = 19'(in_i.elem_2);
    a3 = 19'(in_i.elem_3);
    a4 = 19'(in_i.elem_4);
    a5 = 19'(in_i.elem_5);
    a6 = 19'(in_i.elem_6);
    a7 = 19'(in_i.elem_7);
    a8 = 19'(in_i.elem_8);
    tr = a0 + a4 + a8;
    na = a5 - a7;
    nb = a6 - a2;
    nc = a1 - a3;
    nd = a3 + a1;
    ne = a6 + a2;
    nf = a7 + a5;
    if (tr > 0) begin
      br = rmq_pkg::BrW;
      s  = 19'sd16384 + tr;
      n[0] = na; n[1] = nb; n[2] = nc;
    end else if (a0 > a4 && a0 > a8) begin
      br = rmq_pkg::BrX;
      s  = 19'sd16384 + a0 - a4 - a8;
      n[0] = nd; n[1] = ne; n[2] = na;
    end else if (a4 > a8) begin
      br = rmq_pkg::BrY;
      s  = 19'sd16384 + a4 - a0 - a8;
      n[0] = nd; n[1] = nf; n[2] = nb;
    end else begin
      br = rmq_pkg::BrZ;
      s  = 19'sd16384 + a8 - a0 - a4;
      n[0] = ne; n[1] = nf; n[2] = nc;
    end
    data_d      = '0;
    data_d.br   = br;
    // negative radicand is clamped to zero
    data_d.rad  = (s > 0) ? {1'b0, s[16:0], 12'b0} : '0;
    for (int k = 0; k < rmq_pkg::Lanes; k++) begin
      data_d.neg[k] = n[k][18];
      data_d.mag[k] = n[k][18] ? rmq_pkg::MagW'(-n[k]) : rmq_pkg::MagW'(n[k]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_i.ready) begin
      valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      data_q <= data_d;
    end
  end

endmodule

// ===== hdl/rmq_sqrt_cell.sv =====
// one digit of the integer square root, two radicand bits per cell
// depends on rmq_pkg
module rmq_sqrt_cell (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  rmq_pkg::sqrt_t  in_data_i,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output rmq_pkg::sqrt_t  out_data_o
);

  logic                          valid_q;
  rmq_pkg::sqrt_t                data_q, data_d;
  logic [rmq_pkg::SqRemW-1:0]    rem_sh, trial;

  assign in_ready_o  = !valid_q || out_ready_i;
  assign out_valid_o = valid_q;
  assign out_data_o  = data_q;

  always_comb begin
    data_d     = in_data_i;
    rem_sh     = {in_data_i.rem[rmq_pkg::SqRemW-3:0],
                  in_data_i.rad[rmq_pkg::RadW-1 -: 2]};
    trial      = rmq_pkg::SqRemW'({in_data_i.root, 2'b01});
    data_d.rad = {in_data_i.rad[rmq_pkg::RadW-3:0], 2'b00};
    if (rem_sh >= trial) begin
      data_d.rem  = rem_sh - trial;
      data_d.root = {in_data_i.root[rmq_pkg::RootW-2:0], 1'b1};
    end else begin
      data_d.rem  = rem_sh;
      data_d.root = {in_data_i.root[rmq_pkg::RootW-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      data_q <= data_d;
    end
  end

endmodule

// ===== hdl/rmq_prep.sv =====
// rounds the root and sets up the three dividends with the overflow check
// depends on rmq_pkg
module rmq_prep (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  rmq_pkg::sqrt_t  in_data_i,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output rmq_pkg::div_t   out_data_o
);

  logic                         valid_q;
  rmq_pkg::div_t                data_q, data_d;
  logic [rmq_pkg::RootW-1:0]    q;
  logic [rmq_pkg::RadW-1:0]     dvd;
  logic [rmq_pkg::RadW+2:0]     lim;

  assign in_ready_o  = !valid_q || out_ready_i;
  assign out_valid_o = valid_q;
  assign out_data_o  = data_q;

  always_comb begin
    // round to nearest: remainder above root means the upper neighbor is closer
    q = in_data_i.root +
        rmq_pkg::RootW'(in_data_i.rem > rmq_pkg::SqRemW'(in_data_i.root));
    lim           = {q, 1'b0, 17'b0};
    data_d        = '0;
    data_d.q      = q;
    data_d.br     = in_data_i.br;
    data_d.neg    = in_data_i.neg;
    dvd           = '0;
    for (int k = 0; k < rmq_pkg::Lanes; k++) begin
      dvd = {in_data_i.mag[k], 13'b0} + rmq_pkg::RadW'(q);
      data_d.zero[k] = (in_data_i.mag[k] == '0);
      data_d.ovf[k]  = ({3'b000, dvd} >= lim);
      data_d.rem[k]  = rmq_pkg::DivRemW'(dvd[rmq_pkg::RadW-1:rmq_pkg::DivSteps]);
      data_d.dvd[k]  = dvd;
      data_d.quo[k]  = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      data_q <= data_d;
    end
  end

endmodule

// ===== hdl/rmq_div_cell.sv =====
// one quotient bit of the restoring divide, for all three lanes
// depends on rmq_pkg
module rmq_div_cell (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  rmq_pkg::div_t   in_data_i,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output rmq_pkg::div_t   out_data_o
);

  logic                           valid_q;
  rmq_pkg::div_t                  data_q, data_d;
  logic [rmq_pkg::DivRemW-1:0]    dv, rsh;

  assign in_ready_o  = !valid_q || out_ready_i;
  assign out_valid_o = valid_q;
  assign out_data_o  = data_q;

  always_comb begin
    data_d = in_data_i;
    dv     = rmq_pkg::DivRemW'({in_data_i.q, 1'b0});
    rsh    = '0;
    for (int k = 0; k < rmq_pkg::Lanes; k++) begin
      rsh = {in_data_i.rem[k][rmq_pkg::DivRemW-2:0],
             in_data_i.dvd[k][rmq_pkg::DivSteps-1]};
      data_d.dvd[k] = {in_data_i.dvd[k][rmq_pkg::RadW-2:0], 1'b0};
      if (rsh >= dv) begin
        data_d.rem[k] = rsh - dv;
        data_d.quo[k] = {in_data_i.quo[k][rmq_pkg::QuoW-2:0], 1'b1};
      end else begin
        data_d.rem[k] = rsh;
        data_d.quo[k] = {in_data_i.quo[k][rmq_pkg::QuoW-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      data_q <= data_d;
    end
  end

endmodule

// ===== hdl/rmq_back.sv =====
// output cell: sign, saturation and placement of the four components
// depends on rmq_pkg and rmq_if
module rmq_back (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  rmq_pkg::div_t   in_data_i,
  rmq_out_if.source       out_o
);

  localparam logic [15:0] SatPos = 16'h7fff;
  localparam logic [15:0] SatNeg = 16'h8000;

  logic                valid_q;
  logic [3:0][15:0]    slot_q, slot_d;
  logic [2:0][15:0]    lane;

  assign in_ready_o   = !valid_q || out_o.ready;
  assign out_o.valid  = valid_q;
  assign out_o.quat_x = slot_q[0];
  assign out_o.quat_y = slot_q[1];
  assign out_o.quat_z = slot_q[2];
  assign out_o.quat_w = slot_q[3];

  always_comb begin
    for (int k = 0; k < rmq_pkg::Lanes; k++) begin
      if (in_data_i.zero[k]) begin
        lane[k] = '0;
      end else if (in_data_i.ovf[k]) begin
        lane[k] = in_data_i.neg[k] ? SatNeg : SatPos;
      end else if (!in_data_i.neg[k]) begin
        lane[k] = (in_data_i.quo[k] > 17'd32767) ? SatPos : in_data_i.quo[k][15:0];
      end else begin
        lane[k] = (in_data_i.quo[k] > 17'd32768) ? SatNeg : 16'(-in_data_i.quo[k][15:0]);
      end
    end
    // lanes fill the slots other than the root's, in order
    for (int s = 0; s < 4; s++) begin
      if (s == int'(in_data_i.br)) begin
        slot_d[s] = 16'(in_data_i.q);
      end else if (s < int'(in_data_i.br)) begin
        slot_d[s] = lane[s];
      end else begin
        slot_d[s] = lane[s-1];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      slot_q <= slot_d;
    end
  end

endmodule

// ===== tb/tb_rotation_matrix_to_quaternion.sv =====
// self-checking testbench for rotation_matrix_to_quaternion
// depends on rmq_pkg, rmq_if and the block; drives matrix items, checks quaternion items
module tb_rotation_matrix_to_quaternion;
  timeunit 1ns;
  timeprecision 1ps;

  typedef logic signed [15:0] elem_t;
  typedef struct {
    elem_t m [9];
  } matrix_t;
  typedef struct {
    elem_t x;
    elem_t y;
    elem_t z;
    elem_t w;
  } quat_t;
  typedef struct {
    elem_t m [9];
    bit    has_quat;
    quat_t quat;
  } row_t;

  logic clk_i;
  logic rst_ni;

  rmq_in_if  in_ch ();
  rmq_out_if out_ch ();

  rotation_matrix_to_quaternion u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_ch.sink),
    .out_o  (out_ch.source)
  );

  always begin
    clk_i = 1'b1;
    #4;
    clk_i = 1'b0;
    #4;
  end

  quat_t expected_quats [$];
  int    fail_cnt;
  bit    calm;  // no idling on either side

  function automatic int root_q14(int s);
    longint x;
    longint r;
    if (s <= 0) return 0;
    x = longint'(s) * 4096;
    r = 0;
    while ((r + 1) * (r + 1) <= x) r++;
    if (x - r * r > r) r++;
    return int'(r);
  endfunction

  function automatic elem_t div_q14(int n, int q);
    longint mag;
    longint res;
    if (q <= 0) begin
      if (n > 0) return 16'sd32767;
      if (n < 0) return -16'sd32768;
      return 16'sd0;
    end
    mag = longint'(n < 0 ? -n : n) * 4096;
    res = (2 * mag + q) / (2 * longint'(q));
    if (n < 0) res = -res;
    if (res > 32767) res = 32767;
    if (res < -32768) res = -32768;
    return elem_t'(res);
  endfunction

  function automatic quat_t predict_quat(matrix_t mt);
    int a [9];
    int t;
    int q;
    quat_t r;
    for (int i = 0; i < 9; i++) a[i] = mt.m[i];
    t = a[0] + a[4] + a[8];
    if (t > 0) begin
      q = root_q14(16384 + t);
      r.x = div_q14(a[5] - a[7], q);
      r.y = div_q14(a[6] - a[2], q);
      r.z = div_q14(a[1] - a[3], q);
      r.w = elem_t'(q);
    end else if (a[0] > a[4] && a[0] > a[8]) begin
      q = root_q14(16384 + a[0] - a[4] - a[8]);
      r.x = elem_t'(q);
      r.y = div_q14(a[3] + a[1], q);
      r.z = div_q14(a[6] + a[2], q);
      r.w = div_q14(a[5] - a[7], q);
    end else if (a[4] > a[8]) begin
      q = root_q14(16384 + a[4] - a[0] - a[8]);
      r.x = div_q14(a[3] + a[1], q);
      r.y = elem_t'(q);
      r.z = div_q14(a[7] + a[5], q);
      r.w = div_q14(a[6] - a[2], q);
    end else begin
      q = root_q14(16384 + a[8] - a[0] - a[4]);
      r.x = div_q14(a[6] + a[2], q);
      r.y = div_q14(a[7] + a[5], q);
      r.z = elem_t'(q);
      r.w = div_q14(a[1] - a[3], q);
    end
    return r;
  endfunction

  function automatic row_t mk(int e0, int e1, int e2, int e3, int e4, int e5, int e6,
                              int e7, int e8);
    row_t r;
    r.m = '{elem_t'(e0), elem_t'(e1), elem_t'(e2), elem_t'(e3), elem_t'(e4),
            elem_t'(e5), elem_t'(e6), elem_t'(e7), elem_t'(e8)};
    r.has_quat = 1'b0;
    return r;
  endfunction

  function automatic row_t mkq(row_t r, int x, int y, int z, int w);
    r.has_quat = 1'b1;
    r.quat = '{elem_t'(x), elem_t'(y), elem_t'(z), elem_t'(w)};
    return r;
  endfunction

  function automatic matrix_t random_matrix();
    matrix_t mt;
    int pick;
    int kind;
    pick = $urandom_range(0, 9);
    for (int i = 0; i < 9; i++) begin
      if (pick < 2) mt.m[i] = elem_t'($urandom);
      else mt.m[i] = elem_t'($signed($urandom_range(0, 32768)) - 16384);
    end
    kind = $urandom_range(0, 7);
    // bias diagonal to force the x, y and z branches and a tie on the diagonal
    if (kind == 0) begin
      mt.m[0] = elem_t'($urandom_range(8000, 16384));
      mt.m[4] = elem_t'(-$signed($urandom_range(0, 16384)));
      mt.m[8] = elem_t'(-$signed($urandom_range(0, 16384)));
    end else if (kind == 1) begin
      mt.m[4] = elem_t'($urandom_range(8000, 16384));
      mt.m[0] = elem_t'(-$signed($urandom_range(0, 16384)));
      mt.m[8] = elem_t'(-$signed($urandom_range(0, 16384)));
    end else if (kind == 2) begin
      mt.m[8] = elem_t'($urandom_range(8000, 16384));
      mt.m[0] = elem_t'(-$signed($urandom_range(0, 16384)));
      mt.m[4] = elem_t'(-$signed($urandom_range(0, 16384)));
    end else if (kind == 3) begin
      mt.m[0] = elem_t'(-$signed($urandom_range(16000, 16384)));
      mt.m[4] = mt.m[0];
      mt.m[8] = elem_t'(-$signed($urandom_range(0, 16384)));
    end
    return mt;
  endfunction

  task automatic send_matrix(matrix_t mt);
    while (!calm && $urandom_range(0, 99) < 19) begin
      in_ch.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_ch.valid  <= 1'b1;
    in_ch.elem_0 <= mt.m[0];
    in_ch.elem_1 <= mt.m[1];
    in_ch.elem_2 <= mt.m[2];
    in_ch.elem_3 <= mt.m[3];
    in_ch.elem_4 <= mt.m[4];
    in_ch.elem_5 <= mt.m[5];
    in_ch.elem_6 <= mt.m[6];
    in_ch.elem_7 <= mt.m[7];
    in_ch.elem_8 <= mt.m[8];
    @(posedge clk_i);
    while (!in_ch.ready) @(posedge clk_i);
  endtask

  // sink side: random stalls, compare against oldest expectation
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (expected_quats.size() == 0) begin
          $error("quaternion item with none expected");
          fail_cnt++;
        end else begin
          quat_t e;
          e = expected_quats.pop_front();
          if (out_ch.quat_x !== e.x) begin
            $error("quat_x expected %0d actual %0d", e.x, out_ch.quat_x);
            fail_cnt++;
          end
          if (out_ch.quat_y !== e.y) begin
            $error("quat_y expected %0d actual %0d", e.y, out_ch.quat_y);
            fail_cnt++;
          end
          if (out_ch.quat_z !== e.z) begin
            $error("quat_z expected %0d actual %0d", e.z, out_ch.quat_z);
            fail_cnt++;
          end
          if (out_ch.quat_w !== e.w) begin
            $error("quat_w expected %0d actual %0d", e.w, out_ch.quat_w);
            fail_cnt++;
          end
        end
      end
      out_ch.ready <= calm || ($urandom_range(0, 99) >= 19);
    end
  end

  initial begin
    row_t    rows [$];
    matrix_t mt;

    fail_cnt     = 0;
    calm         = 1'b0;
    rst_ni       = 1'b0;
    in_ch.valid  = 1'b0;
    in_ch.elem_0 = '0;
    in_ch.elem_1 = '0;
    in_ch.elem_2 = '0;
    in_ch.elem_3 = '0;
    in_ch.elem_4 = '0;
    in_ch.elem_5 = '0;
    in_ch.elem_6 = '0;
    in_ch.elem_7 = '0;
    in_ch.elem_8 = '0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    // identity and the half-turns read off directly
    rows.push_back(mkq(mk(16384, 0, 0, 0, 16384, 0, 0, 0, 16384), 0, 0, 0, 16384));
    rows.push_back(mkq(mk(16384, 0, 0, 0, -16384, 0, 0, 0, -16384), 16384, 0, 0, 0));
    rows.push_back(mkq(mk(-16384, 0, 0, 0, 16384, 0, 0, 0, -16384), 0, 16384, 0, 0));
    rows.push_back(mkq(mk(-16384, 0, 0, 0, -16384, 0, 0, 0, 16384), 0, 0, 16384, 0));
    // all zero: z branch by ties, root 8192
    rows.push_back(mkq(mk(0, 0, 0, 0, 0, 0, 0, 0, 0), 0, 0, 8192, 0));
    // diagonal all at the negative extreme: z branch by ties, signed numerators
    rows.push_back(mk(-32768, 100, 5, -100, -32768, 0, 0, 0, -32768));
    rows.push_back(mk(-32768, -100, -5, 100, -32768, 0, -9, 0, -32768));
    // extremes of every element
    rows.push_back(mk(32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767));
    rows.push_back(mk(-32768, -32768, -32768, -32768, -32768, -32768, -32768, -32768,
                      -32768));
    rows.push_back(mk(32767, -32768, 32767, -32768, 32767, -32768, 32767, -32768, 32767));
    rows.push_back(mk(-32768, 32767, -32768, 32767, 32767, -32768, 32767, -32768, -32768));
    // large numerators on the divided terms, the second with a trace of one
    rows.push_back(mk(-16000, 32767, 32767, -32768, -16000, 32767, -32768, -32768, -16000));
    rows.push_back(mk(1, 20000, -20000, -20000, 0, 30000, 20000, -30000, 0));
    // ties on the diagonal fall to later branches
    rows.push_back(mk(-100, 300, 200, 100, -100, 50, -40, 60, -200));
    rows.push_back(mk(-8192, 11585, 0, 11585, -8192, 0, 0, 0, -8192));
    rows.push_back(mk(-16384, 1, 2, 3, -16384, 4, 5, 6, -16384));
    rows.push_back(mk(0, -16384, 0, 16384, 0, 0, 0, 0, 16384));
    rows.push_back(mk(-1, 7, 3, 9, -2, -5, 11, 13, -1));

    foreach (rows[i]) begin
      mt.m = rows[i].m;
      if (rows[i].has_quat) expected_quats.push_back(rows[i].quat);
      else expected_quats.push_back(predict_quat(mt));
      send_matrix(mt);
    end

    for (int n = 0; n < 1150; n++) begin
      calm = (n >= 400 && n < 550);
      mt = random_matrix();
      expected_quats.push_back(predict_quat(mt));
      send_matrix(mt);
    end
    calm = 1'b0;
    in_ch.valid <= 1'b0;

    while (expected_quats.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
    if (fail_cnt == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  initial begin
    #2ms;
    $display("tb: failure");
    $finish;
  end

endmodule
